### rtl/utf8d_pkg.sv
package utf8d_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned REM_W  = 2;

    localparam logic [BYTE_W-1:0] ASCII_MAX  = 8'h7F;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;

    localparam logic [REM_W-1:0] REM_NONE = 2'd0;
    localparam logic [REM_W-1:0] REM_ONE  = 2'd1;
    localparam logic [REM_W-1:0] REM_TWO  = 2'd2;
    localparam logic [REM_W-1:0] REM_THREE = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_string;
    } utf8d_word_t;

    typedef struct packed {
        logic            emit;
        logic [CP_W-1:0] code_point;
    } utf8d_result_t;

endpackage

### rtl/utf8d_byte_if.sv
interface utf8d_byte_if
    import utf8d_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_string;

    modport source (output valid, output data_byte, output end_of_string, input ready);
    modport sink (input valid, input data_byte, input end_of_string, output ready);
endinterface

### rtl/utf8d_cp_if.sv
interface utf8d_cp_if
    import utf8d_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;

    modport source (output valid, output code_point, input ready);
    modport sink (input valid, input code_point, output ready);
endinterface

### rtl/utf8d_in_stage.sv
module utf8d_in_stage
    import utf8d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  utf8d_word_t in_word,
    output logic        word_valid,
    output utf8d_word_t word,
    input  logic        advance
);

    logic        valid_reg;
    logic        valid_next;
    utf8d_word_t word_reg;
    logic        load;

    assign in_ready   = !valid_reg || advance;
    assign load       = in_valid && in_ready;
    assign valid_next = load ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= in_word;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

### rtl/utf8d_decode.sv
module utf8d_decode
    import utf8d_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  utf8d_word_t   word,
    output utf8d_result_t result
);

    logic [REM_W-1:0] remaining_reg;
    logic [REM_W-1:0] remaining_next;
    logic [CP_W-1:0]  partial_reg;
    logic [CP_W-1:0]  partial_next;
    logic [BYTE_W-1:0] b;
    logic [REM_W-1:0] rem_calc;
    logic [CP_W-1:0]  part_calc;
    logic [CP_W-1:0]  shifted;

    assign b       = word.data_byte;
    assign shifted = {partial_reg[CP_W-7:0], b[5:0]};

    always_comb
    begin
        rem_calc          = remaining_reg;
        part_calc         = partial_reg;
        result.emit       = 1'b0;
        result.code_point = '0;
        if (remaining_reg != REM_NONE)
        begin
            if ((b & CONT_MASK) == CONT_CODE)
            begin
                rem_calc  = remaining_reg - REM_ONE;
                part_calc = shifted;
                if (remaining_reg == REM_ONE)
                begin
                    result.emit       = 1'b1;
                    result.code_point = shifted;
                    part_calc         = '0;
                end
            end
            else
            begin
                rem_calc  = REM_NONE;
                part_calc = '0;
            end
        end
        else if (b <= ASCII_MAX)
        begin
            result.emit       = 1'b1;
            result.code_point = {{(CP_W-BYTE_W){1'b0}}, b};
        end
        else if ((b & LEAD2_MASK) == LEAD2_CODE)
        begin
            rem_calc  = REM_ONE;
            part_calc = {{(CP_W-5){1'b0}}, b[4:0]};
        end
        else if ((b & LEAD3_MASK) == LEAD3_CODE)
        begin
            rem_calc  = REM_TWO;
            part_calc = {{(CP_W-4){1'b0}}, b[3:0]};
        end
        else if ((b & LEAD4_MASK) == LEAD4_CODE)
        begin
            rem_calc  = REM_THREE;
            part_calc = {{(CP_W-3){1'b0}}, b[2:0]};
        end
        if (word.end_of_string)
        begin
            rem_calc  = REM_NONE;
            part_calc = '0;
        end
    end

    assign remaining_next = advance ? rem_calc : remaining_reg;
    assign partial_next   = advance ? part_calc : partial_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= REM_NONE;
            partial_reg   <= '0;
        end
        else
        begin
            remaining_reg <= remaining_next;
            partial_reg   <= partial_next;
        end
    end

endmodule

### rtl/utf8d_out_stage.sv
module utf8d_out_stage
    import utf8d_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            word_valid,
    input  utf8d_result_t   result,
    output logic            advance,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [CP_W-1:0] code_point
);

    logic            valid_reg;
    logic            valid_next;
    logic [CP_W-1:0] cp_reg;
    logic            free;

    assign free       = !valid_reg || out_ready;
    assign advance    = word_valid && free;
    assign valid_next = advance ? result.emit : (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.emit)
        begin
            cp_reg <= result.code_point;
        end
    end

    assign out_valid  = valid_reg;
    assign code_point = cp_reg;

endmodule

### rtl/utf8_to_code_point_decoder.sv
// UTF-8 to code point decoder.
// utf8_bytes carries one byte of a UTF-8 string per word, with end_of_string
// marking the last byte of a string. code_points carries one 21-bit code
// point per completed sequence; bytes that do not complete a sequence, and
// malformed bytes, produce no word.
// An accepted byte sits in the input register, is decoded and written into
// the result register once it is free, and its code point is then valid.
// Throughput: one byte per cycle while code_points does not stall, set by
// the single decode step between the input register and the result register.
// When code_points stalls, the result register holds its word and the input
// register still takes one more byte; after that utf8_bytes.ready drops until
// the result is taken.
// Reset clears both valid flags and the pending sequence state; the block
// takes a byte in the first cycle after reset is released.
module utf8_to_code_point_decoder
    import utf8d_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    utf8d_byte_if.sink  utf8_bytes,
    utf8d_cp_if.source  code_points
);

    utf8d_word_t   in_word;
    utf8d_word_t   word;
    logic          word_valid;
    logic          advance;
    utf8d_result_t result;

    assign in_word.data_byte     = utf8_bytes.data_byte;
    assign in_word.end_of_string = utf8_bytes.end_of_string;

    utf8d_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (utf8_bytes.valid),
        .in_ready   (utf8_bytes.ready),
        .in_word    (in_word),
        .word_valid (word_valid),
        .word       (word),
        .advance    (advance)
    );

    utf8d_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .word    (word),
        .result  (result)
    );

    utf8d_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .result     (result),
        .advance    (advance),
        .out_valid  (code_points.valid),
        .out_ready  (code_points.ready),
        .code_point (code_points.code_point)
    );

endmodule

### verif/tb_utf8_to_code_point_decoder.sv
`timescale 1ns / 1ps

module tb_utf8_to_code_point_decoder;
    import utf8d_pkg::*;

    localparam int unsigned RANDOM_WORDS = 1350;
    localparam int unsigned CALM_AFTER   = 1200;
    localparam int unsigned HOLD_START   = 600;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned MAX_REPORTS  = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_string;
        logic              typed;
        logic              emit;
        logic [CP_W-1:0]   code_point;
    } dir_row_t;

    localparam int unsigned DIR_ROWS = 23;

    dir_row_t directed_rows [DIR_ROWS] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, 21'h000000},
        '{8'h7F, 1'b1, 1'b1, 1'b1, 21'h00007F},
        '{8'h80, 1'b0, 1'b1, 1'b0, 21'h000000},
        '{8'hBF, 1'b0, 1'b1, 1'b0, 21'h000000},
        '{8'hF8, 1'b0, 1'b1, 1'b0, 21'h000000},
        '{8'hFF, 1'b0, 1'b1, 1'b0, 21'h000000},
        '{8'hC0, 1'b0, 1'b1, 1'b0, 21'h000000},
        '{8'h80, 1'b0, 1'b1, 1'b1, 21'h000000},
        '{8'hDF, 1'b0, 1'b1, 1'b0, 21'h000000},
        '{8'hBF, 1'b1, 1'b1, 1'b1, 21'h0007FF},
        '{8'hE4, 1'b0, 1'b1, 1'b0, 21'h000000},
        '{8'hB8, 1'b0, 1'b0, 1'b0, 21'h000000},
        '{8'hAD, 1'b0, 1'b0, 1'b0, 21'h000000},
        '{8'hF7, 1'b0, 1'b1, 1'b0, 21'h000000},
        '{8'hBF, 1'b0, 1'b1, 1'b0, 21'h000000},
        '{8'hBF, 1'b0, 1'b1, 1'b0, 21'h000000},
        '{8'hBF, 1'b0, 1'b1, 1'b1, 21'h1FFFFF},
        '{8'hF0, 1'b0, 1'b1, 1'b0, 21'h000000},
        '{8'h9F, 1'b0, 1'b0, 1'b0, 21'h000000},
        '{8'h41, 1'b0, 1'b1, 1'b0, 21'h000000},
        '{8'hE2, 1'b0, 1'b1, 1'b0, 21'h000000},
        '{8'h82, 1'b1, 1'b1, 1'b0, 21'h000000},
        '{8'hAC, 1'b0, 1'b0, 1'b0, 21'h000000}
    };

    logic clk;
    logic rst_n;

    utf8d_byte_if utf8_bytes ();
    utf8d_cp_if   code_points ();

    utf8_to_code_point_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .utf8_bytes  (utf8_bytes),
        .code_points (code_points)
    );

    logic [REM_W-1:0] seq_left;
    logic [CP_W-1:0]  seq_bits;
    logic [CP_W-1:0]  pending_cps [$];
    logic [CP_W-1:0]  oldest_cp;
    int unsigned      mismatch_count;
    int unsigned      idle_cycles;
    bit               calm;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic decode_utf8_byte(input logic [BYTE_W-1:0] b, input logic eos,
                                              output logic [CP_W-1:0] cp);
        logic hit;
        hit = 1'b0;
        cp  = '0;
        if (seq_left != REM_NONE)
        begin
            if ((b & CONT_MASK) == CONT_CODE)
            begin
                seq_bits = {seq_bits[CP_W-7:0], b[5:0]};
                seq_left = seq_left - 1'b1;
                if (seq_left == REM_NONE)
                begin
                    hit      = 1'b1;
                    cp       = seq_bits;
                    seq_bits = '0;
                end
            end
            else
            begin
                seq_left = REM_NONE;
                seq_bits = '0;
            end
        end
        else if (b <= ASCII_MAX)
        begin
            hit = 1'b1;
            cp  = CP_W'(b);
        end
        else if ((b & LEAD2_MASK) == LEAD2_CODE)
        begin
            seq_bits = CP_W'(b[4:0]);
            seq_left = REM_ONE;
        end
        else if ((b & LEAD3_MASK) == LEAD3_CODE)
        begin
            seq_bits = CP_W'(b[3:0]);
            seq_left = REM_TWO;
        end
        else if ((b & LEAD4_MASK) == LEAD4_CODE)
        begin
            seq_bits = CP_W'(b[2:0]);
            seq_left = REM_THREE;
        end
        if (eos)
        begin
            seq_left = REM_NONE;
            seq_bits = '0;
        end
        return hit;
    endfunction

    task automatic note_mismatch(input string what, input logic [CP_W-1:0] want,
                                 input logic [CP_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s: expected code point %06h, got %06h", $realtime, what, want, got);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos, input logic typed,
                             input logic want_emit, input logic [CP_W-1:0] want_cp);
        logic            hit;
        logic [CP_W-1:0] cp;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            utf8_bytes.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        utf8_bytes.valid         <= 1'b1;
        utf8_bytes.data_byte     <= b;
        utf8_bytes.end_of_string <= eos;
        do
            @(posedge clk);
        while (!utf8_bytes.ready);
        hit = decode_utf8_byte(b, eos, cp);
        if (typed)
        begin
            hit = want_emit;
            cp  = want_cp;
        end
        if (hit)
            pending_cps.push_back(cp);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && code_points.valid && code_points.ready)
        begin
            if (pending_cps.size() == 0)
                note_mismatch("unexpected word", '0, code_points.code_point);
            else
            begin
                oldest_cp = pending_cps.pop_front();
                if (code_points.code_point !== oldest_cp)
                    note_mismatch("code point mismatch", oldest_cp, code_points.code_point);
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if ((utf8_bytes.valid && utf8_bytes.ready) ||
                    (code_points.valid && code_points.ready))
                    idle_cycles = 0;
                else
                    idle_cycles++;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int unsigned cycle_count;
        int unsigned n;
        bit          held_off;
        cycle_count = 0;
        held_off    = 1'b0;
        code_points.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!calm && !held_off && cycle_count >= HOLD_START)
            begin
                held_off = 1'b1;
                code_points.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                cycle_count += HOLD_CYCLES;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 8);
                code_points.ready <= 1'b0;
                repeat (n) @(posedge clk);
                cycle_count += n;
            end
            else
            begin
                n = $urandom_range(1, 12);
                code_points.ready <= 1'b1;
                repeat (n) @(posedge clk);
                cycle_count += n;
            end
        end
    end

    initial
    begin
        logic [8:0]        burst [$];
        logic [8:0]        w;
        logic [BYTE_W-1:0] b;
        int unsigned       sent;
        int unsigned       kind;
        int unsigned       len;
        int unsigned       cut;
        int unsigned       r;

        seq_left       = REM_NONE;
        seq_bits       = '0;
        mismatch_count = 0;
        calm           = 1'b0;
        sent           = 0;

        rst_n                    <= 1'b0;
        utf8_bytes.valid         <= 1'b0;
        utf8_bytes.data_byte     <= '0;
        utf8_bytes.end_of_string <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_byte(directed_rows[i].data_byte, directed_rows[i].end_of_string,
                      directed_rows[i].typed, directed_rows[i].emit,
                      directed_rows[i].code_point);

        while (sent < RANDOM_WORDS)
        begin
            burst.delete();
            kind = $urandom_range(0, 15);
            len  = 1;
            if (kind <= 3)
                burst.push_back({1'b0, 1'b0, 7'($urandom_range(0, 127))});
            else if (kind <= 11 || kind == 13 || kind == 14)
            begin
                r = $urandom_range(0, 2);
                if (kind <= 6)
                    len = 2;
                else if (kind <= 9)
                    len = 3;
                else if (kind <= 11)
                    len = 4;
                else
                    len = r + 2;
                case (len)
                    2: b = {3'b110, 5'($urandom)};
                    3: b = {4'b1110, 4'($urandom)};
                    default: b = {5'b11110, 3'($urandom)};
                endcase
                burst.push_back({1'b0, b});
                for (int k = 1; k < len; k++)
                    burst.push_back({1'b0, 2'b10, 6'($urandom)});
                if (kind == 13)
                begin
                    cut = $urandom_range(1, len - 1);
                    while (burst.size() > cut)
                        void'(burst.pop_back());
                    r = $urandom_range(0, 191);
                    b = (r < 128) ? BYTE_W'(r) : BYTE_W'(r + 64);
                    burst.push_back({1'b0, b});
                end
                else if (kind == 14)
                begin
                    cut = $urandom_range(1, len - 1);
                    while (burst.size() > cut)
                        void'(burst.pop_back());
                    burst[cut-1][8] = 1'b1;
                end
            end
            else if (kind == 12)
                burst.push_back({1'b0, 8'($urandom)});
            else
            begin
                len = $urandom_range(1, 3);
                for (int k = 0; k < len; k++)
                    burst.push_back({1'b0, 2'b10, 6'($urandom)});
            end
            if (kind != 14 && $urandom_range(0, 9) == 0)
                burst[burst.size()-1][8] = 1'b1;

            foreach (burst[k])
            begin
                w = burst[k];
                if (sent >= CALM_AFTER)
                    calm = 1'b1;
                send_byte(w[7:0], w[8], 1'b0, 1'b0, '0);
                sent++;
            end
        end

        calm = 1'b1;
        utf8_bytes.valid <= 1'b0;
        while (pending_cps.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
